// ===== src/fee_pkg.sv =====
// ----------------------------------------------------------------------------
// fee_pkg
// Shared constants, codes and payload types of the flash eeprom emulation core.
// ----------------------------------------------------------------------------
`default_nettype none

package fee_pkg;

    localparam int PAGE_BYTES = 1024;
    localparam int SLOTS      = (PAGE_BYTES - 4) / 4;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int DEPTH      = 2 * SLOTS;
    localparam int ADDR_W     = $clog2(DEPTH);

    localparam logic [15:0] PS_ERASED  = 16'hFFFF;
    localparam logic [15:0] PS_RECEIVE = 16'hEEEE;
    localparam logic [15:0] PS_VALID   = 16'h0000;
    localparam logic [31:0] SLOT_ERASED = 32'hFFFF_FFFF;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_INIT  = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam logic [1:0] RES_OK        = 2'd0;
    localparam logic [1:0] RES_NOT_FOUND = 2'd1;
    localparam logic [1:0] RES_NO_PAGE   = 2'd2;
    localparam logic [1:0] RES_FULL      = 2'd3;

    localparam logic [2:0] REG_VAR_ID_0  = 3'd0;
    localparam logic [2:0] REG_VAR_ID_1  = 3'd1;
    localparam logic [2:0] REG_VAR_ID_2  = 3'd2;
    localparam logic [2:0] REG_VAR_ID_3  = 3'd3;
    localparam logic [2:0] REG_VAR_COUNT = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] var_address;
        logic [15:0] value;
    } fee_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] read_data;
    } fee_out_t;

endpackage

`default_nettype wire

// ===== src/fee_ram.sv =====
// ----------------------------------------------------------------------------
// fee_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/flash_eeprom_emulation_core.sv =====
// ----------------------------------------------------------------------------
// flash_eeprom_emulation_core
// Two-page log store emulating eeprom in flash: read, write with page
// transfer, and init recovery of page statuses.
// ----------------------------------------------------------------------------
//  channel  | ports                              | direction
//  ---------+------------------------------------+----------
//  input    | s_valid s_ready s_data             | in
//  result   | m_valid m_ready m_data             | out
//  config   | cfg_valid cfg_ready cfg_index/data | in
//
//  one transaction at a time; a slot check reads and then compares on the
//  single slot ram port, so a read scans the valid page from its last slot
//  down and a write scans up for an erased slot, then erases the old page
//  when it transfers. after reset a clearing pass erases both pages with
//  s_ready low; config writes are taken at all times.
//  a result waiting on m_ready holds off the next input transaction.
`default_nettype none

module flash_eeprom_emulation_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire fee_pkg::fee_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output fee_pkg::fee_out_t     m_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [15:0]      cfg_data
);
    import fee_pkg::*;

    localparam logic [4:0] S_RST0   = 5'd0;
    localparam logic [4:0] S_RST1   = 5'd1;
    localparam logic [4:0] S_IDLE   = 5'd2;
    localparam logic [4:0] S_RD_END = 5'd3;
    localparam logic [4:0] S_W1     = 5'd4;
    localparam logic [4:0] S_W2     = 5'd5;
    localparam logic [4:0] S_CP     = 5'd6;
    localparam logic [4:0] S_CP2    = 5'd7;
    localparam logic [4:0] S_CP3    = 5'd8;
    localparam logic [4:0] S_CP_END = 5'd9;
    localparam logic [4:0] S_OK     = 5'd10;
    localparam logic [4:0] S_I_RD   = 5'd11;
    localparam logic [4:0] S_I_RD2  = 5'd12;
    localparam logic [4:0] S_I0     = 5'd13;
    localparam logic [4:0] S_I1     = 5'd14;
    localparam logic [4:0] S_I2     = 5'd15;
    localparam logic [4:0] S_SC_RD  = 5'd16;
    localparam logic [4:0] S_SC_CHK = 5'd17;
    localparam logic [4:0] S_AP_RD  = 5'd18;
    localparam logic [4:0] S_AP_CHK = 5'd19;
    localparam logic [4:0] S_ER     = 5'd20;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

    logic [4:0]       state_reg, state_next, ret_reg, ret_next;
    logic             page_reg, page_next;
    logic [15:0]      tag_reg, tag_next;
    logic [31:0]      word_reg, word_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             found_reg, found_next;
    logic [15:0]      data_reg, data_next;
    logic [2:0]       k_reg, k_next;
    logic [15:0]      skip_reg, skip_next;
    logic             src_reg, src_next;
    logic [15:0]      in_tag_reg, in_tag_next;
    logic [3:0]       plan_reg, plan_next;
    logic [1:0][15:0] ps_reg, ps_next;
    logic [3:0][15:0] var_id_reg;
    logic [2:0]       var_count_reg;
    logic             out_valid_reg, out_valid_next;
    fee_out_t         out_reg, out_next;

    logic              we;
    logic [31:0]       wdata, rdata;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        tab;
    logic              vp, vp_none;
    logic [3:0]        plan;

    assign addr = page_reg ? ADDR_W'(idx_reg) + ADDR_W'(SLOTS) : ADDR_W'(idx_reg);
    assign tab  = (var_count_reg > 3'd4) ? 3'd4 : var_count_reg;
    assign vp_none = (ps_reg[0] != PS_VALID) && (ps_reg[1] != PS_VALID);
    assign vp   = (ps_reg[0] == PS_VALID) ? 1'b0 : 1'b1;

    assign s_ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    fee_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_slots (
        .aclk (aclk),
        .we   (we),
        .waddr(addr),
        .wdata(wdata),
        .raddr(addr),
        .rdata(rdata)
    );

    // plan bits: erase page 0, erase page 1, page 0 valid, page 1 valid
    always_comb begin
        plan = 4'b0111;
        priority if (ps_reg[0] == PS_ERASED) begin
            if (ps_reg[1] == PS_VALID) plan = 4'b0001;
            else if (ps_reg[1] == PS_RECEIVE) plan = 4'b1001;
        end else if (ps_reg[0] == PS_RECEIVE) begin
            if (ps_reg[1] == PS_ERASED) plan = 4'b0110;
        end else if (ps_reg[0] == PS_VALID) begin
            if (ps_reg[1] == PS_ERASED) plan = 4'b0000;
            else if (ps_reg[1] != PS_VALID) plan = 4'b0010;
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next = ret_reg;
        page_next = page_reg;
        tag_next = tag_reg;
        word_next = word_reg;
        idx_next = idx_reg;
        found_next = found_reg;
        data_next = data_reg;
        k_next = k_reg;
        skip_next = skip_reg;
        src_next = src_reg;
        in_tag_next = in_tag_reg;
        plan_next = plan_reg;
        ps_next = ps_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next = out_reg;
        we = 1'b0;
        wdata = word_reg;

        unique case (state_reg)
            S_RST0: begin
                page_next = 1'b0;
                idx_next = '0;
                ret_next = S_RST1;
                state_next = S_ER;
            end
            S_RST1: begin
                page_next = 1'b1;
                idx_next = '0;
                ret_next = S_IDLE;
                state_next = S_ER;
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    in_tag_next = s_data.var_address;
                    unique case (s_data.action)
                        ACT_READ: begin
                            if (vp_none) begin
                                out_valid_next = 1'b1;
                                out_next = '{status: RES_NO_PAGE, read_data: 16'h0};
                            end else begin
                                page_next = vp;
                                tag_next = s_data.var_address;
                                idx_next = IDX_LAST;
                                ret_next = S_RD_END;
                                state_next = S_SC_RD;
                            end
                        end
                        ACT_WRITE: begin
                            if (vp_none) begin
                                out_valid_next = 1'b1;
                                out_next = '{status: RES_NO_PAGE, read_data: 16'h0};
                            end else begin
                                page_next = vp;
                                src_next = vp;
                                word_next = {s_data.var_address, s_data.value};
                                idx_next = '0;
                                ret_next = S_W1;
                                state_next = S_AP_RD;
                            end
                        end
                        ACT_INIT: begin
                            if (ps_reg[0] == PS_RECEIVE && ps_reg[1] == PS_VALID) begin
                                page_next = 1'b0;
                                idx_next = '0;
                                state_next = S_I_RD;
                            end else begin
                                plan_next = plan;
                                state_next = S_I0;
                            end
                        end
                        default: begin
                            out_valid_next = 1'b1;
                            out_next = '{status: RES_OK, read_data: 16'h0};
                        end
                    endcase
                end
            end
            S_RD_END: begin
                out_valid_next = 1'b1;
                out_next = found_reg ? '{status: RES_OK, read_data: data_reg}
                                     : '{status: RES_NOT_FOUND, read_data: 16'h0};
                state_next = S_IDLE;
            end
            S_W1: begin
                if (found_reg) begin
                    state_next = S_OK;
                end else begin
                    ps_next[!src_reg] = PS_RECEIVE;
                    page_next = !src_reg;
                    idx_next = '0;
                    ret_next = S_W2;
                    state_next = S_AP_RD;
                end
            end
            S_W2: begin
                if (!found_reg) begin
                    out_valid_next = 1'b1;
                    out_next = '{status: RES_FULL, read_data: 16'h0};
                    state_next = S_IDLE;
                end else begin
                    skip_next = in_tag_reg;
                    k_next = '0;
                    state_next = S_CP;
                end
            end
            S_CP: begin
                if (k_reg < tab) begin
                    if (var_id_reg[k_reg[1:0]] != skip_reg) begin
                        page_next = src_reg;
                        tag_next = var_id_reg[k_reg[1:0]];
                        idx_next = IDX_LAST;
                        ret_next = S_CP2;
                        state_next = S_SC_RD;
                    end else begin
                        k_next = k_reg + 3'd1;
                    end
                end else begin
                    state_next = S_CP_END;
                end
            end
            S_CP2: begin
                if (found_reg) begin
                    page_next = !src_reg;
                    word_next = {var_id_reg[k_reg[1:0]], data_reg};
                    idx_next = '0;
                    ret_next = S_CP3;
                    state_next = S_AP_RD;
                end else begin
                    k_next = k_reg + 3'd1;
                    state_next = S_CP;
                end
            end
            S_CP3: begin
                k_next = k_reg + 3'd1;
                state_next = S_CP;
            end
            S_CP_END: begin
                ps_next[!src_reg] = PS_VALID;
                page_next = src_reg;
                idx_next = '0;
                ret_next = S_OK;
                state_next = S_ER;
            end
            S_OK: begin
                out_valid_next = 1'b1;
                out_next = '{status: RES_OK, read_data: 16'h0};
                state_next = S_IDLE;
            end
            S_I_RD: begin
                state_next = S_I_RD2;
            end
            S_I_RD2: begin
                skip_next = rdata[31:16];
                src_next = 1'b1;
                k_next = '0;
                state_next = S_CP;
            end
            S_I0: begin
                state_next = S_I1;
                if (plan_reg[0]) begin
                    page_next = 1'b0;
                    idx_next = '0;
                    ret_next = S_I1;
                    state_next = S_ER;
                end
            end
            S_I1: begin
                state_next = S_I2;
                if (plan_reg[1]) begin
                    page_next = 1'b1;
                    idx_next = '0;
                    ret_next = S_I2;
                    state_next = S_ER;
                end
            end
            S_I2: begin
                if (plan_reg[2]) ps_next[0] = PS_VALID;
                if (plan_reg[3]) ps_next[1] = PS_VALID;
                state_next = S_OK;
            end
            S_SC_RD: begin
                state_next = S_SC_CHK;
            end
            S_SC_CHK: begin
                if (rdata[31:16] == tag_reg) begin
                    found_next = 1'b1;
                    data_next = rdata[15:0];
                    state_next = ret_reg;
                end else if (idx_reg == '0) begin
                    found_next = 1'b0;
                    state_next = ret_reg;
                end else begin
                    idx_next = idx_reg - IDX_ONE;
                    state_next = S_SC_RD;
                end
            end
            S_AP_RD: begin
                state_next = S_AP_CHK;
            end
            S_AP_CHK: begin
                if (rdata == SLOT_ERASED) begin
                    we = 1'b1;
                    found_next = 1'b1;
                    state_next = ret_reg;
                end else if (idx_reg == IDX_LAST) begin
                    found_next = 1'b0;
                    state_next = ret_reg;
                end else begin
                    idx_next = idx_reg + IDX_ONE;
                    state_next = S_AP_RD;
                end
            end
            S_ER: begin
                we = 1'b1;
                wdata = SLOT_ERASED;
                ps_next[page_reg] = PS_ERASED;
                if (idx_reg == IDX_LAST) begin
                    state_next = ret_reg;
                end else begin
                    idx_next = idx_reg + IDX_ONE;
                end
            end
            default: begin
                state_next = S_RST0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RST0;
            ret_reg <= S_IDLE;
            ps_reg <= {PS_ERASED, PS_ERASED};
            out_valid_reg <= 1'b0;
            var_id_reg <= {16'd3, 16'd2, 16'd1, 16'd0};
            var_count_reg <= 3'd3;
        end else begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            ps_reg <= ps_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_VAR_ID_0:  var_id_reg[0] <= cfg_data;
                    REG_VAR_ID_1:  var_id_reg[1] <= cfg_data;
                    REG_VAR_ID_2:  var_id_reg[2] <= cfg_data;
                    REG_VAR_ID_3:  var_id_reg[3] <= cfg_data;
                    REG_VAR_COUNT: var_count_reg <= cfg_data[2:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        page_reg <= page_next;
        tag_reg <= tag_next;
        word_reg <= word_next;
        idx_reg <= idx_next;
        found_reg <= found_next;
        data_reg <= data_next;
        k_reg <= k_next;
        skip_reg <= skip_next;
        src_reg <= src_next;
        in_tag_reg <= in_tag_next;
        plan_reg <= plan_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ===== src/fee_checker.sv =====
// ----------------------------------------------------------------------------
// fee_checker
// Port level checks of the flash eeprom emulation core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module fee_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire fee_pkg::fee_out_t m_data
);
    import fee_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no new transaction while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready with result pending");

    // one transaction at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after accept");

    // failed operations carry zero data
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != RES_OK |-> m_data.read_data == 16'h0)
        else $error("nonzero data on failed result");

endmodule

bind flash_eeprom_emulation_core fee_checker u_fee_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

`default_nettype wire

// ===== test/flash_eeprom_emulation_core_test.sv =====
// ----------------------------------------------------------------------------
// flash_eeprom_emulation_core_test
// Self-checking bench for the two-page flash eeprom emulation core. Reads,
// writes with page transfer, init recovery and the unused action are sent
// under random idling on both channels. A local model of both pages and
// the tabled variables predicts every result, and the bench checks each one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module flash_eeprom_emulation_core_test;
    import fee_pkg::*;

    localparam int CYCLE_LIMIT = 15000000;
    localparam int NO_PAGE     = 2;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    fee_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    fee_out_t m_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    flash_eeprom_emulation_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // local copy of the flash contents and the variable table
    logic [15:0] page_state [2];
    logic [31:0] flash_slots [DEPTH];
    logic [15:0] tab_id [4];
    logic [2:0]  tab_count;

    fee_in_t  send_queue [$];
    fee_out_t expected_results [$];
    int       send_idle = 0;
    int       recv_idle = 0;
    bit       send_pause = 1'b0;
    int       hold_requests = 0;
    int       holds_done = 0;
    int       hold_left = 0;
    int       errors = 0;
    int       cycles = 0;
    int       n_reads = 0, n_writes = 0, n_inits = 0, n_transfers = 0, n_checked = 0;

    function automatic int active_page();
        if (page_state[0] == PS_VALID) return 0;
        if (page_state[1] == PS_VALID) return 1;
        return NO_PAGE;
    endfunction

    function automatic void erase_page(int p);
        page_state[p] = PS_ERASED;
        for (int i = 0; i < SLOTS; i++) flash_slots[p * SLOTS + i] = SLOT_ERASED;
    endfunction

    function automatic void format_pages();
        erase_page(0);
        page_state[0] = PS_VALID;
        erase_page(1);
    endfunction

    function automatic bit append_slot(int p, logic [15:0] data, logic [15:0] tag);
        for (int i = 0; i < SLOTS; i++) begin
            if (flash_slots[p * SLOTS + i] == SLOT_ERASED) begin
                flash_slots[p * SLOTS + i] = {tag, data};
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit latest_value(int p, logic [15:0] tag, output logic [15:0] data);
        data = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (flash_slots[p * SLOTS + i][31:16] == tag) begin
                data = flash_slots[p * SLOTS + i][15:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic int tabled();
        return (tab_count > 3'd4) ? 4 : int'(tab_count);
    endfunction

    function automatic logic [1:0] store_write(logic [15:0] tag, logic [15:0] data);
        int oldp, newp;
        logic [15:0] v;
        oldp = active_page();
        if (oldp == NO_PAGE) return RES_NO_PAGE;
        if (append_slot(oldp, data, tag)) return RES_OK;
        newp = oldp ^ 1;
        page_state[newp] = PS_RECEIVE;
        if (!append_slot(newp, data, tag)) return RES_FULL;
        for (int i = 0; i < tabled(); i++) begin
            if (tab_id[i] != tag && latest_value(oldp, tab_id[i], v))
                void'(append_slot(newp, v, tab_id[i]));
        end
        erase_page(oldp);
        page_state[newp] = PS_VALID;
        n_transfers++;
        return RES_OK;
    endfunction

    function automatic void recover_pages();
        logic [15:0] s0, s1, first_tag, v;
        s0 = page_state[0];
        s1 = page_state[1];
        if (s0 == PS_ERASED) begin
            if (s1 == PS_VALID) begin
                erase_page(0);
            end else if (s1 == PS_RECEIVE) begin
                erase_page(0);
                page_state[1] = PS_VALID;
            end else begin
                format_pages();
            end
        end else if (s0 == PS_RECEIVE) begin
            if (s1 == PS_VALID) begin
                first_tag = flash_slots[0][31:16];
                for (int i = 0; i < tabled(); i++) begin
                    if (tab_id[i] != first_tag && latest_value(1, tab_id[i], v))
                        void'(append_slot(0, v, tab_id[i]));
                end
                page_state[0] = PS_VALID;
                erase_page(1);
            end else if (s1 == PS_ERASED) begin
                erase_page(1);
                page_state[0] = PS_VALID;
            end else begin
                format_pages();
            end
        end else if (s0 == PS_VALID) begin
            if (s1 == PS_VALID) format_pages();
            else if (s1 != PS_ERASED) erase_page(1);
        end else begin
            format_pages();
        end
    endfunction

    function automatic fee_out_t predict_result(fee_in_t x);
        fee_out_t r;
        int p;
        logic [15:0] v;
        r = '0;
        case (x.action)
            ACT_READ: begin
                n_reads++;
                p = active_page();
                if (p == NO_PAGE) r.status = RES_NO_PAGE;
                else if (!latest_value(p, x.var_address, v)) r.status = RES_NOT_FOUND;
                else r.read_data = v;
            end
            ACT_WRITE: begin
                n_writes++;
                r.status = store_write(x.var_address, x.value);
            end
            ACT_INIT: begin
                n_inits++;
                recover_pages();
            end
            default: r.status = RES_OK;
        endcase
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) expected_results.push_back(predict_result(s_data));
            if (!s_valid || s_ready) begin
                if (send_queue.size() > 0 && !send_pause && $urandom_range(99) >= send_idle) begin
                    s_data  <= send_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with long hold-offs on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (holds_done != hold_requests) begin
            holds_done <= holds_done + 1;
            hold_left <= 3000;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // monitor
    always @(posedge aclk) begin
        fee_out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected: status %0d read_data %h",
                       m_data.status, m_data.read_data);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                n_checked++;
                if (m_data.status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, m_data.status);
                    errors++;
                end
                if (m_data.read_data !== exp_r.read_data) begin
                    $error("read_data: expected %h, actual %h", exp_r.read_data, m_data.read_data);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < REG_VAR_COUNT) tab_id[idx] = val;
        else if (idx == REG_VAR_COUNT) tab_count = val[2:0];
    endtask

    task automatic load_table(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                              logic [15:0] d, logic [2:0] n);
        write_reg(REG_VAR_ID_0, a);
        write_reg(REG_VAR_ID_1, b);
        write_reg(REG_VAR_ID_2, c);
        write_reg(REG_VAR_ID_3, d);
        write_reg(REG_VAR_COUNT, {13'd0, n});
    endtask

    task automatic queue_item(logic [1:0] act, logic [15:0] tag, logic [15:0] val);
        fee_in_t x;
        x.action = act;
        x.var_address = tag;
        x.value = val;
        send_queue.push_back(x);
    endtask

    task automatic drain();
        while (send_queue.size() > 0 || s_valid || expected_results.size() > 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic queue_random(int count);
        int r, t;
        logic [1:0]  act;
        logic [15:0] tag;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            act = (r < 70) ? ACT_WRITE : (r < 92) ? ACT_READ : (r < 96) ? ACT_INIT : ACT_SPARE;
            t = $urandom_range(99);
            if (t < 50) tag = tab_id[$urandom_range(3)];
            else if (t < 85) tag = 16'($urandom_range(7));
            else if (t < 95) tag = 16'($urandom);
            else tag = 16'hFFFF;
            queue_item(act, tag, 16'($urandom));
        end
    endtask

    initial begin
        for (int i = 0; i < 4; i++) tab_id[i] = 16'(i);
        tab_count = 3'd3;
        page_state[0] = PS_ERASED;
        page_state[1] = PS_ERASED;
        for (int i = 0; i < DEPTH; i++) flash_slots[i] = SLOT_ERASED;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: no valid page, format, extremes, erased tag, unused action
        load_table(16'h0000, 16'h0004, 16'h0006, 16'hFFFF, 3'd0);
        @(negedge aclk);
        queue_item(ACT_READ, 16'h0000, 16'h0000);
        queue_item(ACT_WRITE, 16'h0001, 16'hFFFF);
        queue_item(ACT_SPARE, 16'hFFFF, 16'hFFFF);
        queue_item(ACT_INIT, 16'h0000, 16'h0000);
        queue_item(ACT_READ, 16'h0001, 16'h0000);
        queue_item(ACT_READ, 16'hFFFF, 16'h0000);
        queue_item(ACT_WRITE, 16'h0000, 16'h0000);
        queue_item(ACT_WRITE, 16'hFFFF, 16'hFFFF);
        queue_item(ACT_WRITE, 16'hFFFF, 16'h0000);
        queue_item(ACT_WRITE, 16'h0004, 16'hA5A5);
        queue_item(ACT_WRITE, 16'h0004, 16'h5A5A);
        queue_item(ACT_WRITE, 16'h8000, 16'h8000);
        queue_item(ACT_READ, 16'h0004, 16'h0000);
        queue_item(ACT_READ, 16'hFFFF, 16'hFFFF);
        queue_item(ACT_READ, 16'h0000, 16'h0000);
        queue_item(ACT_READ, 16'h8000, 16'h0000);
        queue_item(ACT_READ, 16'h7FFF, 16'h0000);
        queue_item(ACT_INIT, 16'hFFFF, 16'hFFFF);
        queue_item(ACT_SPARE, 16'h0000, 16'h0000);
        queue_item(ACT_READ, 16'h0004, 16'h0000);
        drain();

        load_table(16'h0000, 16'h0001, 16'h0002, 16'h0003, 3'd4);
        @(negedge aclk);
        send_idle = 25;
        recv_idle = 66;
        queue_random(150);
        drain();

        load_table(16'h0005, 16'h0000, 16'h0007, 16'hFFFF, 3'd1);
        @(negedge aclk);
        send_idle = 66;
        recv_idle = 25;
        queue_random(150);
        drain();

        load_table(16'hFFFF, 16'h0002, 16'h0004, 16'h0006, 3'd7);
        @(negedge aclk);
        send_idle = 0;
        recv_idle = 0;
        queue_random(75);
        hold_requests++;
        // sender pauses until every outstanding result is back
        while (send_queue.size() > 0 || s_valid) @(negedge aclk);
        send_pause = 1'b1;
        while (expected_results.size() > 0) @(negedge aclk);
        send_pause = 1'b0;
        queue_random(75);
        drain();

        $display("checked %0d results: %0d reads, %0d writes, %0d inits, %0d page transfers",
                 n_checked, n_reads, n_writes, n_inits, n_transfers);
        $display("table settings with 0, 1, 4 and 7 variables, idling on both channels");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
